// ----- hdl/zobrist_key_and_transposition_table_unit_assert.svh -----
// Assertion macros for the Zobrist key and transposition table unit
`ifndef ZOBRIST_KEY_AND_TRANSPOSITION_TABLE_UNIT_ASSERT_SVH
`define ZOBRIST_KEY_AND_TRANSPOSITION_TABLE_UNIT_ASSERT_SVH

// Concurrent assertion, disabled while reset is asserted
`define ZKTT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion, checked at every edge including reset
`define ZKTT_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/zktt_pkg.sv -----
// Shared types, command codes and default sizes for the Zobrist key unit
package zktt_pkg;

    // field widths
    localparam int CMD_W    = 3;
    localparam int PIECE_W  = 3;
    localparam int SQUARE_W = 6;
    localparam int WORD_W   = 64;
    localparam int MOVE_W   = 6;

    // default sizes
    localparam int TABLE_ENTRIES_DEF = 16384;
    localparam int PIECE_KINDS_DEF   = 6;
    localparam int BOARD_SQUARES_DEF = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STORE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ZERO   = 3'd5;

    // input transaction payload
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic                side;
        logic [PIECE_W-1:0]  piece_kind;
        logic [SQUARE_W-1:0] square;
        logic                table_select;
        logic [WORD_W-1:0]   word_value;
        logic [MOVE_W-1:0]   move_from;
        logic [MOVE_W-1:0]   move_to;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic                hit;
        logic [MOVE_W-1:0]   found_from;
        logic [MOVE_W-1:0]   found_to;
        logic [WORD_W-1:0]   position_key;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // capture input, read memories at input address
        logic mod_step;  // one 8-bit digit of the key remainder
        logic rd_item;   // read memories at the captured address
        logic commit;    // apply the command, load the result register
        logic clr_step;  // zero one table entry
    } t_ctl;

    // datapath to controller status
    typedef struct packed {
        logic in_entry;     // incoming command uses the table
        logic slot_direct;  // slot is a mask of the key
        logic mod_last;     // remainder finishes this cycle
        logic item_clear;   // captured command is a table clear
        logic clr_last;     // clearing pass at last entry
    } t_stat;

endpackage

// ----- hdl/zktt_stream_if.sv -----
// Valid/ready stream channel carrying one payload per transaction
interface zktt_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/zobrist_key_and_transposition_table_unit.sv -----
// Commands are taken one at a time: the accept reads the word and entry memories, then
// the commit (held while the result register is full) applies it and loads the result.
// When TABLE_ENTRIES is not a power of two, store and lookup go through the accept,
// a remainder of the 64-bit key (8 bits a cycle), an entry read and the commit.
// Clear table and reset: a pass zeroing all 2*TABLE_ENTRIES entries, no command taken.
// Reset (synchronous, active low) also zeroes the running key and lock.
module zobrist_key_and_transposition_table_unit #(
    parameter int TABLE_ENTRIES = zktt_pkg::TABLE_ENTRIES_DEF,
    parameter int PIECE_KINDS   = zktt_pkg::PIECE_KINDS_DEF,
    parameter int BOARD_SQUARES = zktt_pkg::BOARD_SQUARES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    zktt_stream_if.sink    i_cmd_ch,
    zktt_stream_if.source  o_res_ch
);

    zktt_pkg::t_ctl      w_ctl;
    zktt_pkg::t_stat     w_stat;
    zktt_pkg::t_out_item w_res;
    logic                w_in_ready;
    logic                w_out_valid;

    // sequencing
    zktt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd_ch.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_res_ch.ready),
        .o_out_valid (w_out_valid),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl)
    );

    // tables and running values
    zktt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PIECE_KINDS   (PIECE_KINDS),
        .BOARD_SQUARES (BOARD_SQUARES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_cmd_ch.data),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    assign i_cmd_ch.ready = w_in_ready;
    assign o_res_ch.valid = w_out_valid;
    assign o_res_ch.data  = w_res;

endmodule

// ----- hdl/zktt_ctrl.sv -----
// Controller state machine for the Zobrist key unit
module zktt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  zktt_pkg::t_stat i_stat,
    output zktt_pkg::t_ctl  o_ctl
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MOD   = 5'b00100,
        S_READ  = 5'b01000,
        S_EXEC  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state = (i_stat.in_entry && !i_stat.slot_direct) ? S_MOD : S_EXEC;
                end
            end
            S_MOD: begin
                o_ctl.mod_step = 1'b1;
                if (i_stat.mod_last) n_state = S_READ;
            end
            S_READ: begin
                o_ctl.rd_item = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // hold until the result register is free
                if (w_out_free) begin
                    o_ctl.commit = 1'b1;
                    n_state = i_stat.item_clear ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // state register, starts with the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/zktt_dp.sv -----
// Datapath: word tables, transposition table, running key and lock
module zktt_dp #(
    parameter int TABLE_ENTRIES = zktt_pkg::TABLE_ENTRIES_DEF,
    parameter int PIECE_KINDS   = zktt_pkg::PIECE_KINDS_DEF,
    parameter int BOARD_SQUARES = zktt_pkg::BOARD_SQUARES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zktt_pkg::t_in_item  i_item,
    input  zktt_pkg::t_ctl      i_ctl,
    output zktt_pkg::t_stat     o_stat,
    output zktt_pkg::t_out_item o_res
);

    localparam int WORD_DEPTH = 2 * PIECE_KINDS * BOARD_SQUARES;
    localparam int WIDX_W     = $clog2(WORD_DEPTH);
    localparam int ENT_DEPTH  = 2 * TABLE_ENTRIES;
    localparam int EIDX_W     = $clog2(ENT_DEPTH);
    localparam int SLOT_W     = $clog2(TABLE_ENTRIES);
    localparam bit SLOT_POW2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam int KEY_W      = zktt_pkg::WORD_W;
    localparam int MOVE_W     = zktt_pkg::MOVE_W;

    typedef struct packed {
        logic [KEY_W-1:0]  lock;
        logic [MOVE_W-1:0] from;
        logic [MOVE_W-1:0] to;
    } t_entry;

    // residue of each key bit weight
    typedef logic [KEY_W-1:0][SLOT_W-1:0] t_pow_tab;

    // piece and square inside the configured board
    function automatic logic f_in_range(input zktt_pkg::t_in_item it);
        f_in_range = (32'(it.piece_kind) < 32'(PIECE_KINDS))
                  && (32'(it.square) < 32'(BOARD_SQUARES));
    endfunction

    // (side, piece, square) to word table address
    function automatic logic [WIDX_W-1:0] f_widx(input zktt_pkg::t_in_item it);
        logic [31:0] v;
        v = (32'(it.side) * 32'(PIECE_KINDS) + 32'(it.piece_kind)) * 32'(BOARD_SQUARES)
          + 32'(it.square);
        f_widx = v[WIDX_W-1:0];
    endfunction

    // (side, slot) to entry address
    function automatic logic [EIDX_W-1:0] f_eidx(input logic side,
                                                 input logic [SLOT_W-1:0] slot);
        logic [EIDX_W:0] v;
        v = (side ? (EIDX_W+1)'(TABLE_ENTRIES) : '0) + (EIDX_W+1)'(slot);
        f_eidx = v[EIDX_W-1:0];
    endfunction

    // 2^i mod TABLE_ENTRIES for every key bit position
    function automatic t_pow_tab f_pow_mod();
        t_pow_tab tab;
        longint   d;
        d = 1;
        for (int i = 0; i < KEY_W; i++) begin
            tab[i] = SLOT_W'(d);
            d      = (2 * d) % TABLE_ENTRIES;
        end
        return tab;
    endfunction

    logic [KEY_W-1:0]  key_mem  [WORD_DEPTH];
    logic [KEY_W-1:0]  lock_mem [WORD_DEPTH];
    t_entry            ent_mem  [ENT_DEPTH];

    zktt_pkg::t_in_item  r_item;
    zktt_pkg::t_in_item  w_src;
    zktt_pkg::t_out_item r_res, n_res;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [KEY_W-1:0]    r_lock, n_lock;
    logic [KEY_W-1:0]    r_kw, r_lw;
    t_entry              r_ent;
    logic [WIDX_W-1:0]   w_widx, r_widx;
    logic                w_win, r_win;
    logic [EIDX_W-1:0]   w_eidx, r_eidx;
    logic [EIDX_W-1:0]   r_clr_cnt;
    logic                w_clr_last;
    logic [SLOT_W-1:0]   w_slot;
    logic                w_mod_last;
    logic                w_rd;
    logic                w_ent_we;
    logic [EIDX_W-1:0]   w_ent_waddr;
    t_entry              w_ent_wdata;

    // slot = running key mod table entries
    if (SLOT_POW2) begin : g_mask
        assign w_slot     = r_key[SLOT_W-1:0];
        assign w_mod_last = 1'b1;
    end else begin : g_rem
        localparam int DIG_W    = 8;
        localparam int DIGITS   = KEY_W / DIG_W;
        localparam int DIGIDX_W = $clog2(DIG_W);
        localparam int DCNT_W   = $clog2(DIGITS);
        localparam int KIDX_W   = $clog2(KEY_W);
        localparam int ACC_W    = SLOT_W + 4;
        localparam t_pow_tab POW_MOD = f_pow_mod();

        logic [SLOT_W-1:0] r_rem;
        logic [DCNT_W-1:0] r_dig;
        logic [ACC_W-1:0]  w_sum, w_red;

        // partial remainder plus the residues of this digit's set bits
        always_comb begin
            logic [KIDX_W-1:0] v_pos;
            w_sum = ACC_W'(r_rem);
            for (int j = 0; j < DIG_W; j++) begin
                v_pos = {r_dig, DIGIDX_W'(j)};
                if (r_key[v_pos]) w_sum = w_sum + ACC_W'(POW_MOD[v_pos]);
            end
        end

        // subtract the largest multiple of the table size that fits
        always_comb begin
            w_red = w_sum;
            for (int k = 1; k <= DIG_W; k++) begin
                if (w_sum >= ACC_W'(k * TABLE_ENTRIES))
                    w_red = w_sum - ACC_W'(k * TABLE_ENTRIES);
            end
        end

        // remainder accumulation, one 8-bit key digit per cycle
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rem <= '0;
                r_dig <= '0;
            end else if (i_ctl.accept) begin
                r_rem <= '0;
                r_dig <= '0;
            end else if (i_ctl.mod_step) begin
                r_rem <= w_red[SLOT_W-1:0];
                r_dig <= r_dig + 1'b1;
            end
        end

        assign w_slot     = r_rem;
        assign w_mod_last = (r_dig == DCNT_W'(DIGITS - 1));
    end

    // read address source: incoming transaction or captured one
    assign w_src  = i_ctl.accept ? i_item : r_item;
    assign w_win  = f_in_range(w_src);
    assign w_widx = w_win ? f_widx(w_src) : '0;
    assign w_eidx = f_eidx(w_src.side, w_slot);
    assign w_rd   = i_ctl.accept || i_ctl.rd_item;

    // capture the transaction
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) r_item <= i_item;
    end

    // address bookkeeping for the commit cycle
    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_widx <= w_widx;
            r_win  <= w_win;
            r_eidx <= w_eidx;
        end
    end

    // key word table
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && r_item.cmd == zktt_pkg::CMD_LOAD && r_win && !r_item.table_select)
            key_mem[r_widx] <= r_item.word_value;
        if (w_rd) r_kw <= key_mem[w_widx];
    end

    // lock word table
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && r_item.cmd == zktt_pkg::CMD_LOAD && r_win && r_item.table_select)
            lock_mem[r_widx] <= r_item.word_value;
        if (w_rd) r_lw <= lock_mem[w_widx];
    end

    // entry write port: clearing pass or store
    assign w_ent_we    = i_ctl.clr_step
                      || (i_ctl.commit && r_item.cmd == zktt_pkg::CMD_STORE);
    assign w_ent_waddr = i_ctl.clr_step ? r_clr_cnt : r_eidx;
    always_comb begin
        w_ent_wdata = '0;
        if (!i_ctl.clr_step) begin
            w_ent_wdata.lock = r_lock;
            w_ent_wdata.from = r_item.move_from;
            w_ent_wdata.to   = r_item.move_to;
        end
    end

    // transposition table
    always_ff @(posedge i_clk) begin
        if (w_ent_we) ent_mem[w_ent_waddr] <= w_ent_wdata;
        if (w_rd) r_ent <= ent_mem[w_eidx];
    end

    // clearing pass address counter
    assign w_clr_last = (r_clr_cnt == EIDX_W'(ENT_DEPTH - 1));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_ctl.clr_step) begin
            r_clr_cnt <= w_clr_last ? '0 : r_clr_cnt + 1'b1;
        end
    end

    // command execution
    always_comb begin
        n_key  = r_key;
        n_lock = r_lock;
        n_res  = '0;
        case (r_item.cmd)
            zktt_pkg::CMD_TOGGLE: begin
                if (r_win) begin
                    n_key  = r_key ^ r_kw;
                    n_lock = r_lock ^ r_lw;
                end
            end
            zktt_pkg::CMD_LOOKUP: begin
                if (r_ent.lock == r_lock) begin
                    n_res.hit        = 1'b1;
                    n_res.found_from = r_ent.from;
                    n_res.found_to   = r_ent.to;
                end
            end
            zktt_pkg::CMD_ZERO: begin
                n_key  = '0;
                n_lock = '0;
            end
            default: ;
        endcase
        n_res.position_key = n_key;
    end

    // running key and lock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_lock <= '0;
        end else if (i_ctl.commit) begin
            r_key  <= n_key;
            r_lock <= n_lock;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) r_res <= n_res;
    end

    // status to the controller
    always_comb begin
        o_stat             = '0;
        o_stat.in_entry    = (i_item.cmd == zktt_pkg::CMD_STORE)
                          || (i_item.cmd == zktt_pkg::CMD_LOOKUP);
        o_stat.slot_direct = SLOT_POW2;
        o_stat.mod_last    = w_mod_last;
        o_stat.item_clear  = (r_item.cmd == zktt_pkg::CMD_CLEAR);
        o_stat.clr_last    = w_clr_last;
    end

    assign o_res = r_res;

endmodule

// ----- hdl/zktt_checker.sv -----
// Port-level assertions for the Zobrist key unit, bound to the top level
`include "zobrist_key_and_transposition_table_unit_assert.svh"

module zktt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input zktt_pkg::t_out_item i_out_data
);

    // a waiting result stays offered
    `ZKTT_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")

    // a waiting result keeps its payload
    `ZKTT_ASSERT_RST(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_data), "result changed while stalled")

    // one command at a time: no transaction right after another
    `ZKTT_ASSERT_RST(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "command taken while busy")

    // reset starts the clearing pass, no command taken
    `ZKTT_ASSERT(a_reset_clear, i_clk, !i_rst_n |=> !i_in_ready, "command taken during clearing pass")

endmodule

bind zobrist_key_and_transposition_table_unit zktt_checker u_zktt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd_ch.valid),
    .i_in_ready  (i_cmd_ch.ready),
    .i_out_valid (o_res_ch.valid),
    .i_out_ready (o_res_ch.ready),
    .i_out_data  (o_res_ch.data)
);
